// ===== rtl/irac_pkg.sv =====
// Package for the IR air-conditioner frame decoder.
// Holds the item types, queue entry type, register codes and frame constants.
// No dependencies.
`default_nettype none

package irac_pkg;

    // Intervals at or beyond this position within one frame are ignored.
    localparam int MAX_INTERVALS = 1024;
    localparam int POS_W         = $clog2(MAX_INTERVALS + 1);

    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_THRESHOLD = 1'd0,
        REG_HEADER_SKIP   = 1'd1
    } cfg_reg_t;

    localparam logic [14:0] THRESH_RESET = 15'd800;
    localparam logic [3:0]  SKIP_RESET   = 4'd3;

    localparam logic [9:0] BITS_MAX     = 10'd1023;
    localparam logic [6:0] BYTE_SWING   = 7'd11;
    localparam logic [6:0] BYTE_TEMP    = 7'd13;
    localparam logic [6:0] BYTE_FANMODE = 7'd25;
    localparam logic [6:0] BYTE_POWER   = 7'd27;
    localparam logic [7:0] SWING_CODE   = 8'd129;
    localparam logic [5:0] TEMP_MIN     = 6'd16;
    localparam logic [5:0] TEMP_MAX     = 6'd32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [15:0] interval;
        logic               frame_end;
    } interval_item_t;

    typedef struct packed {
        logic       power_on;
        logic [5:0] temperature;
        logic [2:0] fan_level;
        logic       swing_auto;
        logic [3:0] ac_mode;
        logic [9:0] bit_count;
    } frame_result_t;

    // What the front end hands to the back end for one interval.
    typedef struct packed {
        logic has_bit;
        logic bit_val;
        logic last;
    } queue_entry_t;

endpackage

`default_nettype wire

// ===== rtl/ir_aircon_frame_decoder.sv =====
// Pulse-distance IR air-conditioner frame decoder, top level.
// Throughput: one interval item per cycle; the input stalls only when the queue
// fills behind a frame end whose result has not been taken yet.
// A frame_end item's result is registered after the item leaves the queue.
// Reset (aresetn low, synchronous) clears the frame state, the queue and
// the result valid flag, and restores bit_threshold to 800 and header_skip to 3.
`default_nettype none

module ir_aircon_frame_decoder import irac_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Interval items in.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire interval_item_t        s_item,
    // Frame results out.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output frame_result_t              m_item
);

    // The front end decides per interval whether it yields a data bit and
    // whether it closes the frame; only those intervals enter the queue.
    // Classification is combinational, so an accepted item is written into
    // the queue at its accepting edge and read from there by the back end.
    logic         s_accept;
    logic         front_push;
    queue_entry_t front_entry;
    logic         q_full;
    logic         q_not_empty;
    logic         q_pop;
    queue_entry_t q_entry;

    // The front end only stalls when the queue is full, which happens only
    // while a finished result waits on the output and the entries behind the
    // next frame end pile up.
    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;

    irac_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (s_accept),
        .item      (s_item),
        .push      (front_push),
        .entry     (front_entry)
    );

    irac_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .wr_entry  (front_entry),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .rd_entry  (q_entry)
    );

    // The back end drains the queue every cycle; it holds only a frame-end
    // entry while the previous result still sits unaccepted on the output.
    irac_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

`default_nettype wire

// ===== rtl/irac_front.sv =====
// Front end: holds the configuration registers, counts intervals in the frame
// and turns each accepted interval into a queue entry. Depends on irac_pkg.
`default_nettype none

module irac_front import irac_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  accept,
    input  wire interval_item_t        item,
    output logic                       push,
    output queue_entry_t               entry
);

    logic [14:0]      thresh_reg;
    logic [3:0]       skip_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             in_range;
    logic [16:0]      magnitude;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
            skip_reg   <= SKIP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BIT_THRESHOLD: thresh_reg <= cfg_wdata[14:0];
                REG_HEADER_SKIP:   skip_reg   <= cfg_wdata[3:0];
                default:           ;
            endcase
        end
    end

    assign in_range  = pos_reg < POS_W'(MAX_INTERVALS);
    // Magnitude of a space; only meaningful when the sign bit is set.
    assign magnitude = 17'h10000 - {1'b0, item.interval};

    always_comb begin
        entry.has_bit = in_range && (pos_reg >= POS_W'(skip_reg)) && item.interval[15];
        entry.bit_val = magnitude >= {2'b00, thresh_reg};
        entry.last    = item.frame_end;
        push          = accept && (entry.has_bit || entry.last);
        pos_next      = pos_reg;
        if (accept) begin
            if (item.frame_end) begin
                pos_next = '0;
            end else if (in_range) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_INTERVALS))
        else $error("interval position passed its saturation point");

endmodule

`default_nettype wire

// ===== rtl/irac_queue.sv =====
// Short queue of decoded entries between the front end and the back end.
// Depends on irac_pkg.
`default_nettype none

module irac_queue import irac_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire queue_entry_t wr_entry,
    output logic              full,
    output logic              not_empty,
    input  wire logic         pop,
    output queue_entry_t      rd_entry
);

    queue_entry_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]      count_reg;

    assign full      = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign rd_entry  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

// ===== rtl/irac_back.sv =====
// Back end: packs decoded bits into bytes, keeps the four bytes of interest
// and registers one result per frame end. Depends on irac_pkg.
`default_nettype none

module irac_back import irac_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_not_empty,
    input  wire queue_entry_t q_entry,
    output logic              q_pop,
    output logic              m_valid,
    input  wire logic         m_ready,
    output frame_result_t     m_item
);

    logic [9:0]    bit_pos_reg, bit_pos_upd;
    logic [7:0]    asm_reg, asm_upd;
    logic [7:0]    swing_reg, swing_upd;
    logic [7:0]    temp_reg, temp_upd;
    logic [7:0]    fanmode_reg, fanmode_upd;
    logic [7:0]    power_reg, power_upd;
    logic          m_valid_reg;
    frame_result_t m_item_reg, result;
    logic          out_free;
    logic          do_bit;
    logic [2:0]    shift;
    logic [6:0]    byte_idx;
    logic [7:0]    asm_new;
    logic [5:0]    temp_raw;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_not_empty && (!q_entry.last || out_free);
    assign shift    = bit_pos_reg[2:0];
    assign byte_idx = bit_pos_reg[9:3];
    assign do_bit   = q_pop && q_entry.has_bit && (bit_pos_reg != BITS_MAX);
    assign asm_new  = ((shift == 3'd0) ? 8'd0 : asm_reg) | (8'(q_entry.bit_val) << shift);

    always_comb begin
        bit_pos_upd = bit_pos_reg;
        asm_upd     = asm_reg;
        swing_upd   = swing_reg;
        temp_upd    = temp_reg;
        fanmode_upd = fanmode_reg;
        power_upd   = power_reg;
        if (do_bit) begin
            bit_pos_upd = bit_pos_reg + 10'd1;
            asm_upd     = asm_new;
            if (byte_idx == BYTE_SWING)   swing_upd   = asm_new;
            if (byte_idx == BYTE_TEMP)    temp_upd    = asm_new;
            if (byte_idx == BYTE_FANMODE) fanmode_upd = asm_new;
            if (byte_idx == BYTE_POWER)   power_upd   = asm_new;
        end
    end

    // Result is built from the bytes as they stand after this entry's bit.
    always_comb begin
        temp_raw = temp_upd[7:2];
        result.power_on = power_upd[4];
        priority if (temp_raw > TEMP_MAX) begin
            result.temperature = TEMP_MAX;
        end else if (temp_raw < TEMP_MIN) begin
            result.temperature = TEMP_MIN;
        end else begin
            result.temperature = temp_raw;
        end
        result.fan_level  = fanmode_upd[6:4];
        result.swing_auto = swing_upd == SWING_CODE;
        result.ac_mode    = fanmode_upd[3:0];
        result.bit_count  = bit_pos_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_pos_reg <= '0;
            asm_reg     <= '0;
            swing_reg   <= '0;
            temp_reg    <= '0;
            fanmode_reg <= '0;
            power_reg   <= '0;
        end else if (q_pop && q_entry.last) begin
            bit_pos_reg <= '0;
            asm_reg     <= '0;
            swing_reg   <= '0;
            temp_reg    <= '0;
            fanmode_reg <= '0;
            power_reg   <= '0;
        end else begin
            bit_pos_reg <= bit_pos_upd;
            asm_reg     <= asm_upd;
            swing_reg   <= swing_upd;
            temp_reg    <= temp_upd;
            fanmode_reg <= fanmode_upd;
            power_reg   <= power_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop && q_entry.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_entry.last) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_frame_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_entry.last) |=> (bit_pos_reg == '0) && (power_reg == '0))
        else $error("frame state not cleared after frame end");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_entry.last) |=> m_valid_reg)
        else $error("frame end produced no result");

endmodule

`default_nettype wire
